// ----- rtl/rmwh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwh_pkg
// Shared constants, codes and controller/datapath interface types for the
// ray marching wall height block.
// ----------------------------------------------------------------------------
package rmwh_pkg;

   localparam int GRID_DIM   = 64;
   localparam int CELL_BITS  = $clog2(GRID_DIM);
   localparam int ADDR_BITS  = 2 * CELL_BITS;
   localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
   localparam int ANGLE_BITS = 12;

   // Positions hold start plus up to 1024 steps of under one cell each.
   localparam int POS_BITS   = 28;
   localparam int MAG_BITS   = 17;
   localparam int MUL_BITS   = 27;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int SQ_BITS    = 54;
   localparam int DIST_BITS  = 27;
   localparam int SQRT_ITERS = 27;
   localparam int DIV_ITERS  = 32;
   localparam int TRIG_STEPS = 10;

   localparam logic [MAG_BITS-1:0] ONE_Q16 = 17'h10000;
   localparam logic [MAG_BITS-1:0] SIN_C1  = 17'd102944;
   localparam logic [MAG_BITS-1:0] SIN_C3  = 17'd42334;
   localparam logic [MAG_BITS-1:0] SIN_C5  = 17'd4926;

   typedef enum logic [2:0] {
      CSR_MAP_WIDTH    = 3'd0,
      CSR_MAP_HEIGHT   = 3'd1,
      CSR_MAX_STEPS    = 3'd2,
      CSR_HEIGHT_SCALE = 3'd3,
      CSR_STEP_LENGTH  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_TRIG,
      ST_FETCH,
      ST_MARCH,
      ST_SQ0,
      ST_SQ1,
      ST_SQRT,
      ST_DINIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       clr_en;
      logic       load;
      logic       mem_wr;
      logic       trig_en;
      logic [3:0] trig_step;
      logic       march_init;
      logic       march_en;
      logic       sq0;
      logic       sq1;
      logic       sqrt_en;
      logic       div_init;
      logic       div_en;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic wall;
      logic steps_over;
      logic sqrt_last;
      logic div_last;
      logic rsp_busy;
   } status_type;

endpackage

// ----- rtl/rmwh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwh_ctrl
// Sequencer for the grid clear, cell writes and the ray phases: sine and
// cosine, marching, distance squares, square root, division and result.
// ----------------------------------------------------------------------------
module rmwh_ctrl
   import rmwh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [3:0] tstep_ff, tstep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         tstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         tstep_ff <= tstep_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) state_in = req_action ? ST_TRIG : ST_WRITE;
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_TRIG: if (tstep_ff == 4'(TRIG_STEPS - 1)) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_MARCH;
         ST_MARCH: if (status.wall || status.steps_over) state_in = ST_SQ0;
         ST_SQ0: state_in = ST_SQ1;
         ST_SQ1: state_in = ST_SQRT;
         ST_SQRT: if (status.sqrt_last) state_in = ST_DINIT;
         ST_DINIT: state_in = ST_DIV;
         ST_DIV: if (status.div_last) state_in = ST_DONE;
         ST_DONE: if (!status.rsp_busy) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      tstep_in  = '0;
      cmd.trig_step = tstep_ff;
      case (state_ff)
         ST_CLEAR: cmd.clr_en = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WRITE: cmd.mem_wr = 1'b1;
         ST_TRIG: begin
            cmd.trig_en = 1'b1;
            tstep_in    = tstep_ff + 4'd1;
         end
         ST_FETCH: cmd.march_init = 1'b1;
         ST_MARCH: cmd.march_en = 1'b1;
         ST_SQ0: cmd.sq0 = 1'b1;
         ST_SQ1: cmd.sq1 = 1'b1;
         ST_SQRT: cmd.sqrt_en = 1'b1;
         ST_DINIT: cmd.div_init = 1'b1;
         ST_DIV: cmd.div_en = 1'b1;
         ST_DONE: cmd.rsp_load = !status.rsp_busy;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- rtl/rmwh_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwh_dp
// Datapath: configuration registers, wall grid memory, shared multiplier,
// march positions, square root and restoring divider, result register.
// ----------------------------------------------------------------------------
module rmwh_dp
   import rmwh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   input  logic [23:0] req_pos_x,
   input  logic [23:0] req_pos_y,
   input  logic [ANGLE_BITS-1:0] req_ray_angle,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic        req_cell_wall,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [15:0] rsp_wall_height,
   output logic        rsp_hit_wall,
   output logic [10:0] rsp_steps_taken
);

   logic [6:0]  map_width_ff, map_height_ff;
   logic [9:0]  max_steps_ff;
   logic [15:0] height_scale_ff, step_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= 7'd45;
         map_height_ff   <= 7'd45;
         max_steps_ff    <= 10'd400;
         height_scale_ff <= 16'd300;
         step_length_ff  <= 16'd6554;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_MAP_WIDTH:    map_width_ff    <= csr_wdata[6:0];
            CSR_MAP_HEIGHT:   map_height_ff   <= csr_wdata[6:0];
            CSR_MAX_STEPS:    max_steps_ff    <= csr_wdata[9:0];
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            CSR_STEP_LENGTH:  step_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latched input item.
   logic signed [POS_BITS-1:0] x0_ff, y0_ff;
   logic [1:0]                 quad_ff;
   logic [MAG_BITS-1:0]        t_ff;
   logic [5:0]                 wcx_ff, wcy_ff;
   logic                       wval_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff   <= POS_BITS'(signed'(req_pos_x));
         y0_ff   <= POS_BITS'(signed'(req_pos_y));
         quad_ff <= req_ray_angle[ANGLE_BITS-1 -: 2];
         t_ff    <= MAG_BITS'(req_ray_angle[ANGLE_BITS-3:0]) << (18 - ANGLE_BITS);
         wcx_ff  <= req_cell_x;
         wcy_ff  <= req_cell_y;
         wval_ff <= req_cell_wall;
      end
   end

   // Trig and step deltas through the shared multiplier.
   logic [MAG_BITS-1:0]  t2_ff, acc_ff, st_ff, ct_ff, dxm_ff, dym_ff;
   logic [MAG_BITS-1:0]  tv, cmag, smag, psh;
   logic                 cneg, sneg;
   logic [MUL_BITS-1:0]  mul_a, mul_b;
   logic [PROD_BITS-1:0] prod;
   logic [DIST_BITS-1:0] ax, ay;

   assign tv   = cmd.trig_step[2] ? (ONE_Q16 - t_ff) : t_ff;
   assign cmag = quad_ff[0] ? st_ff : ct_ff;
   assign smag = quad_ff[0] ? ct_ff : st_ff;
   assign cneg = (quad_ff == 2'd1) || (quad_ff == 2'd2);
   assign sneg = quad_ff[1];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.sq0) begin
         mul_a = ax;
         mul_b = ax;
      end else if (cmd.sq1) begin
         mul_a = ay;
         mul_b = ay;
      end else if (cmd.trig_step[3]) begin
         mul_a = MUL_BITS'(cmd.trig_step[0] ? smag : cmag);
         mul_b = MUL_BITS'(step_length_ff);
      end else begin
         case (cmd.trig_step[1:0])
            2'd0: begin mul_a = MUL_BITS'(tv);    mul_b = MUL_BITS'(tv);     end
            2'd1: begin mul_a = MUL_BITS'(t2_ff); mul_b = MUL_BITS'(SIN_C5); end
            2'd2: begin mul_a = MUL_BITS'(t2_ff); mul_b = MUL_BITS'(acc_ff); end
            default: begin mul_a = MUL_BITS'(tv); mul_b = MUL_BITS'(acc_ff); end
         endcase
      end
   end

   assign prod = mul_a * mul_b;
   assign psh  = prod[16 +: MAG_BITS];

   always_ff @(posedge clock) begin
      if (cmd.trig_en) begin
         if (cmd.trig_step[3]) begin
            if (cmd.trig_step[0]) dym_ff <= psh;
            else dxm_ff <= psh;
         end else begin
            case (cmd.trig_step[1:0])
               2'd0: t2_ff  <= psh;
               2'd1: acc_ff <= SIN_C3 - psh;
               2'd2: acc_ff <= SIN_C1 - psh;
               default: begin
                  if (cmd.trig_step[2]) ct_ff <= (psh > ONE_Q16) ? ONE_Q16 : psh;
                  else st_ff <= (psh > ONE_Q16) ? ONE_Q16 : psh;
               end
            endcase
         end
      end
   end

   // March positions and the grid read pipeline.
   logic signed [POS_BITS-1:0] x_ff, y_ff, dx, dy, nx, ny, rx, ry, ex, ey;
   logic [10:0]                steps_ff;
   logic                       hit_ff, rd_bit_ff, oob_ff, oob;
   logic [POS_BITS-17:0]       rcx, rcy;
   logic [ADDR_BITS-1:0]       rd_addr, wr_addr, clr_addr_ff;
   logic                       wr_in_grid;
   logic                       grid_mem [GRID_CELLS];

   assign dx = cneg ? -POS_BITS'(dxm_ff) : POS_BITS'(dxm_ff);
   assign dy = sneg ? -POS_BITS'(dym_ff) : POS_BITS'(dym_ff);
   assign nx = x_ff + dx;
   assign ny = y_ff + dy;
   assign rx = cmd.march_init ? x0_ff : nx;
   assign ry = cmd.march_init ? y0_ff : ny;
   assign rcx = rx[POS_BITS-1:16];
   assign rcy = ry[POS_BITS-1:16];
   assign oob = rx[POS_BITS-1] || ry[POS_BITS-1]
             || (rcx >= (POS_BITS-16)'(map_width_ff)) || (rcy >= (POS_BITS-16)'(map_height_ff))
             || (32'(rcx) >= GRID_DIM) || (32'(rcy) >= GRID_DIM);
   assign rd_addr = {rcy[CELL_BITS-1:0], rcx[CELL_BITS-1:0]};
   assign wr_addr = {CELL_BITS'(wcy_ff), CELL_BITS'(wcx_ff)};
   assign wr_in_grid = (32'(wcx_ff) < GRID_DIM) && (32'(wcy_ff) < GRID_DIM);

   always_ff @(posedge clock) begin
      if (cmd.clr_en) grid_mem[clr_addr_ff] <= 1'b0;
      else if (cmd.mem_wr && wr_in_grid) grid_mem[wr_addr] <= wval_ff;
      if (cmd.march_init || cmd.march_en) begin
         rd_bit_ff <= grid_mem[rd_addr];
         oob_ff    <= oob;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else if (cmd.clr_en) clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   assign status.wall       = oob_ff || rd_bit_ff;
   assign status.steps_over = steps_ff >= 11'(max_steps_ff);
   assign status.clr_last   = &clr_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.march_init) begin
         x_ff     <= x0_ff;
         y_ff     <= y0_ff;
         steps_ff <= '0;
      end else if (cmd.march_en) begin
         hit_ff <= status.wall;
         if (!status.wall) begin
            x_ff     <= nx;
            y_ff     <= ny;
            steps_ff <= steps_ff + 11'd1;
         end
      end
   end

   // Distance: squares, bitwise square root, then restoring division.
   logic [SQ_BITS-1:0]   sq_ff, v_ff, r_ff, bit_ff, rb;
   logic [5:0]           cnt_ff;
   logic [DIST_BITS-1:0] dist_ff, rem_ff;
   logic [DIST_BITS:0]   rem_sh;
   logic [31:0]          q_ff;

   assign ex = x_ff - x0_ff;
   assign ey = y_ff - y0_ff;
   assign ax = DIST_BITS'(ex[POS_BITS-1] ? -ex : ex);
   assign ay = DIST_BITS'(ey[POS_BITS-1] ? -ey : ey);
   assign rb = r_ff + bit_ff;
   assign rem_sh = {rem_ff, q_ff[31]};

   always_ff @(posedge clock) begin
      if (cmd.sq0) sq_ff <= prod;
      if (cmd.sq1) begin
         v_ff   <= sq_ff + prod;
         r_ff   <= '0;
         bit_ff <= SQ_BITS'(1) << (2 * (SQRT_ITERS - 1));
      end else if (cmd.sqrt_en) begin
         if (v_ff >= rb) begin
            v_ff <= v_ff - rb;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         dist_ff <= r_ff[DIST_BITS-1:0];
         rem_ff  <= '0;
         q_ff    <= {height_scale_ff, 16'h0000};
      end else if (cmd.div_en) begin
         if (rem_sh >= {1'b0, dist_ff}) begin
            rem_ff <= DIST_BITS'(rem_sh - {1'b0, dist_ff});
            q_ff   <= {q_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIST_BITS-1:0];
            q_ff   <= {q_ff[30:0], 1'b0};
         end
      end
      if (cmd.sq1 || cmd.div_init) cnt_ff <= '0;
      else if (cmd.sqrt_en || cmd.div_en) cnt_ff <= cnt_ff + 6'd1;
   end

   assign status.sqrt_last = cnt_ff == 6'(SQRT_ITERS - 1);
   assign status.div_last  = cnt_ff == 6'(DIV_ITERS - 1);

   // Result register; a new result may load in the cycle the old one transfers.
   logic        rsp_valid_ff;
   logic [15:0] height_ff;
   logic        rhit_ff;
   logic [10:0] rsteps_ff;

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         height_ff <= ((dist_ff == '0) || (|q_ff[31:16])) ? 16'hFFFF : q_ff[15:0];
         rhit_ff   <= hit_ff;
         rsteps_ff <= steps_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wall_height = height_ff;
   assign rsp_hit_wall    = rhit_ff;
   assign rsp_steps_taken = rsteps_ff;

endmodule

// ----- rtl/ray_march_wall_height.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_march_wall_height
// Fixed-step ray marcher over a one-bit wall grid, returning a wall height.
// ----------------------------------------------------------------------------
// After reset the block clears the 4096-cell grid, one cell a cycle, and
// accepts no item until the clear is done. A ray computes sine, cosine and
// step deltas on one shared multiplier, marches one step per cycle as set by
// the single grid read port, then forms two squares, runs 27 square root
// iterations and 32 division iterations. One item is worked at a time; the
// next is accepted while the last result still waits in the output register.
module ray_march_wall_height
   import rmwh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x[23:0], pos_y[47:24], ray_angle[59:48], cell_x[65:60], cell_y[71:66],
   // cell_wall[72], zero fill above
   input  logic [79:0] req_tdata,
   // action[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // wall_height[15:0], hit_wall[16], steps_taken[27:17], zero fill above
   output logic [31:0] rsp_tdata
);

   cmd_type     cmd;
   status_type  status;
   logic [15:0] wall_height;
   logic        hit_wall;
   logic [10:0] steps_taken;

   rmwh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rmwh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_pos_x       (req_tdata[23:0]),
      .req_pos_y       (req_tdata[47:24]),
      .req_ray_angle   (req_tdata[59:48]),
      .req_cell_x      (req_tdata[65:60]),
      .req_cell_y      (req_tdata[71:66]),
      .req_cell_wall   (req_tdata[72]),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_wall_height (wall_height),
      .rsp_hit_wall    (hit_wall),
      .rsp_steps_taken (steps_taken)
   );

   assign rsp_tdata = {4'b0000, steps_taken, hit_wall, wall_height};

endmodule

// ----- rtl/rmwh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwh_checker
// Port-level checks on the result channel of the ray marcher.
// ----------------------------------------------------------------------------
module rmwh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result holds until it transfers.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:17] <= 11'd1024)
      else $error("step count out of range");

   // The step limit can only end a march that moved at least once.
   a_limit_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> rsp_tdata[27:17] != 11'd0)
      else $error("step limit reached without a step");

   // No step means zero distance, so the height saturates.
   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27:17] == 11'd0 |-> rsp_tdata[15:0] == 16'hFFFF)
      else $error("zero distance without saturated height");

endmodule

bind ray_march_wall_height rmwh_checker u_rmwh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- dv/wall_height_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_height_checker
// Watches the request, response and register ports of the ray marcher, keeps
// its own copy of the wall grid and registers, predicts each ray's wall
// height, hit flag and step count, and compares every response transfer.
// ----------------------------------------------------------------------------
module wall_height_checker
   import rmwh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          errors,
   output int          outstanding
);

   typedef struct packed {
      logic [10:0] steps_taken;
      logic        hit_wall;
      logic [15:0] wall_height;
   } ray_result_type;

   bit             wall_map [GRID_CELLS];
   logic [6:0]     cols_in_use, rows_in_use;
   logic [9:0]     step_limit;
   logic [15:0]    scale_reg, step_len_reg;
   ray_result_type expected_heights [$];

   function automatic longint unsigned quarter_sine(longint unsigned t);
      longint unsigned t2, p;
      t2 = (t * t) >> 16;
      p  = SIN_C3 - ((t2 * SIN_C5) >> 16);
      p  = SIN_C1 - ((t2 * p) >> 16);
      p  = (t * p) >> 16;
      if (p > ONE_Q16) p = ONE_Q16;
      return p;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit blocked(longint px, longint py);
      longint cx, cy;
      if (px < 0 || py < 0) return 1'b1;
      cx = px >>> 16;
      cy = py >>> 16;
      if (cx >= cols_in_use || cy >= rows_in_use) return 1'b1;
      if (cx >= GRID_DIM || cy >= GRID_DIM) return 1'b1;
      return wall_map[cy * GRID_DIM + cx];
   endfunction

   function automatic ray_result_type march_ray(logic [23:0] sx, logic [23:0] sy,
                                                logic [11:0] angle);
      ray_result_type  res;
      longint unsigned t, st, ct, cmag, smag, rdist, h, ax, ay;
      logic            cneg, sneg, hit;
      longint          x0, y0, x, y, dx, dy;
      int              n;
      t  = longint'(angle[9:0]) << 6;
      st = quarter_sine(t);
      ct = quarter_sine(ONE_Q16 - t);
      case (angle[11:10])
         2'd0: begin smag = st; sneg = 0; cmag = ct; cneg = 0; end
         2'd1: begin smag = ct; sneg = 0; cmag = st; cneg = 1; end
         2'd2: begin smag = st; sneg = 1; cmag = ct; cneg = 1; end
         default: begin smag = ct; sneg = 1; cmag = st; cneg = 0; end
      endcase
      dx = longint'((cmag * step_len_reg) >> 16);
      dy = longint'((smag * step_len_reg) >> 16);
      if (cneg) dx = -dx;
      if (sneg) dy = -dy;
      x0 = longint'(signed'(sx));
      y0 = longint'(signed'(sy));
      x = x0;
      y = y0;
      n = 0;
      hit = 0;
      forever begin
         if (blocked(x, y)) begin
            hit = 1;
            break;
         end
         x = x + dx;
         y = y + dy;
         n++;
         if (n > step_limit) break;
      end
      ax = (x >= x0) ? longint'(x - x0) : longint'(x0 - x);
      ay = (y >= y0) ? longint'(y - y0) : longint'(y0 - y);
      rdist = root_floor(ax * ax + ay * ay);
      if (rdist == 0) begin
         h = 16'hFFFF;
      end else begin
         h = (longint'(scale_reg) << 16) / rdist;
         if (h > 16'hFFFF) h = 16'hFFFF;
      end
      res.wall_height = h[15:0];
      res.hit_wall    = hit;
      res.steps_taken = n[10:0];
      return res;
   endfunction

   task automatic report(string what, int unsigned got, int unsigned want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      ray_result_type got, want;
      if (reset) begin
         foreach (wall_map[i]) wall_map[i] = 1'b0;
         cols_in_use  = 7'd45;
         rows_in_use  = 7'd45;
         step_limit   = 10'd400;
         scale_reg    = 16'd300;
         step_len_reg = 16'd6554;
         expected_heights.delete();
         errors       = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MAP_WIDTH:    cols_in_use  = csr_wdata[6:0];
               CSR_MAP_HEIGHT:   rows_in_use  = csr_wdata[6:0];
               CSR_MAX_STEPS:    step_limit   = csr_wdata[9:0];
               CSR_HEIGHT_SCALE: scale_reg    = csr_wdata;
               CSR_STEP_LENGTH:  step_len_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[27:0];
            if (expected_heights.size() == 0) begin
               report("unexpected response, wall_height", got.wall_height, 0);
            end else begin
               want = expected_heights.pop_front();
               if (got.wall_height != want.wall_height)
                  report("wall_height", got.wall_height, want.wall_height);
               if (got.hit_wall != want.hit_wall)
                  report("hit_wall", got.hit_wall, want.hit_wall);
               if (got.steps_taken != want.steps_taken)
                  report("steps_taken", got.steps_taken, want.steps_taken);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser)
               expected_heights.push_back(march_ray(req_tdata[23:0], req_tdata[47:24],
                                                    req_tdata[59:48]));
            else
               wall_map[{req_tdata[71:66], req_tdata[65:60]}] = req_tdata[72];
         end
      end
      outstanding <= expected_heights.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for ray_march_wall_height: directed and random grid writes
// and rays over several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;
   import rmwh_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   int          errors, outstanding;
   int          send_idle_pct = 0, stall_pct = 0, hold_left = 0, cycles = 0;
   int          cols = 45, rows = 45;

   always #2 clock = ~clock;

   ray_march_wall_height dut (.*);
   wall_height_checker chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send(logic act, logic [23:0] px, logic [23:0] py, logic [11:0] ang,
                       logic [5:0] cx, logic [5:0] cy, logic wall);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'b0, wall, cy, cx, ang, py, px};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_cell(int x, int y, bit wall);
      send(1'b0, 24'($urandom), 24'($urandom), 12'($urandom), 6'(x), 6'(y), wall);
   endtask

   task automatic cast(int px, int py, int ang);
      send(1'b1, 24'(px), 24'(py), 12'(ang), 6'($urandom), 6'($urandom), 1'($urandom));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      // The count of pending results is registered, so it lags the last transfer.
      @(posedge clock);
      wait (outstanding == 0 && hold_left == 0);
      // A trailing cell write may still be in progress.
      repeat (20) @(posedge clock);
   endtask

   task automatic set_regs(int w, int h, int steps, int scale, int len);
      csr_we <= 1'b1;
      csr_addr <= CSR_MAP_WIDTH;    csr_wdata <= 16'(w);     @(posedge clock);
      csr_addr <= CSR_MAP_HEIGHT;   csr_wdata <= 16'(h);     @(posedge clock);
      csr_addr <= CSR_MAX_STEPS;    csr_wdata <= 16'(steps); @(posedge clock);
      csr_addr <= CSR_HEIGHT_SCALE; csr_wdata <= 16'(scale); @(posedge clock);
      csr_addr <= CSR_STEP_LENGTH;  csr_wdata <= 16'(len);   @(posedge clock);
      csr_we <= 1'b0;
      cols = w;
      rows = h;
   endtask

   task automatic random_item();
      int span_x, span_y;
      span_x = (cols < 1) ? 1 : (cols > 64 ? 64 : cols);
      span_y = (rows < 1) ? 1 : (rows > 64 ? 64 : rows);
      if ($urandom_range(3) == 0) begin
         write_cell($urandom_range(span_x - 1), $urandom_range(span_y - 1),
                    $urandom_range(9) < 3);
      end else if ($urandom_range(9) < 8) begin
         cast($urandom_range(span_x * 65536 - 1), $urandom_range(span_y * 65536 - 1),
              $urandom_range(4095));
      end else begin
         cast($urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int settings [8][5] = '{
         '{45, 45, 400, 300, 6554},
         '{0, 0, 1, 1, 1},
         '{127, 127, 0, 65535, 65535},
         '{64, 64, 1023, 65535, 1},
         '{1, 1, 5, 1000, 20000},
         '{64, 64, 60, 65535, 30000},
         '{20, 30, 200, 4000, 9000},
         '{45, 45, 400, 300, 6554}
      };
      int count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under reset settings.
      write_cell(20, 10, 1);
      write_cell(3, 3, 1);
      write_cell(63, 63, 1);
      cast(32'h058000, 32'h0A8000, 0);
      cast(32'h058000, 32'h0A8000, 1024);
      cast(32'h058000, 32'h0A8000, 2048);
      cast(32'h058000, 32'h0A8000, 3072);
      cast(32'h038000, 32'h038000, 512);
      cast(32'h800000, 32'h058000, 100);
      cast(32'h7FFFFF, 32'h7FFFFF, 4095);
      cast(32'h058000, 32'h800000, 1024);
      cast(32'h000000, 32'h000000, 512);
      write_cell(3, 3, 0);
      cast(32'h038000, 32'h038000, 512);
      cast(32'h2CFFFF, 32'h2CFFFF, 2560);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         set_regs(settings[ph][0], settings[ph][1], settings[ph][2],
                  settings[ph][3], settings[ph][4]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         if (ph == 5) hold_left = 3000;
         count = (settings[ph][2] > 300 && settings[ph][4] < 100) ? 30 : 110;
         for (int i = 0; i < count; i++) begin
            if (ph == 6 && i == 50) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               wait (outstanding == 0);
            end
            random_item();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
